[src/hpb_pkg.sv]
// shared types and constants for the heater pwm block
package hpb_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [7:0] PWM_PERIOD_RESET = 8'd100;
    localparam logic [7:0] DUTY_MAX_RESET   = 8'd97;
    localparam logic [7:0] DUTY_MIN_RESET   = 8'd3;
    localparam logic [7:0] SETPOINT_RESET   = 8'd50;

    // both buttons up; the reset pattern matches no button state at all
    localparam logic [3:0] BUTTONS_RELEASED   = 4'd3;
    localparam logic [3:0] LAST_BUTTONS_RESET = 4'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PWM_PERIOD = 2'd0,
        REG_DUTY_MAX   = 2'd1,
        REG_DUTY_MIN   = 2'd2
    } hpb_reg_idx_t;

    typedef struct packed {
        logic [7:0] pwm_period;
        logic [7:0] duty_max;
        logic [7:0] duty_min;
    } hpb_cfg_t;

    typedef struct packed {
        logic       manual_mode;
        logic [1:0] buttons_n;
        logic       host_pwm;
    } hpb_item_t;

    typedef struct packed {
        logic       square_wave;
        logic       heater_on;
        logic [7:0] duty_setpoint;
    } hpb_result_t;

endpackage

[src/hpb_ifs.sv]
// request channel interfaces for tick input and result output
interface hpb_in_if;
    logic       valid;
    logic       ready;
    logic       manual_mode;
    logic [1:0] buttons_n;
    logic       host_pwm;

    modport source (output valid, output manual_mode, output buttons_n, output host_pwm,
                    input ready);
    modport sink (input valid, input manual_mode, input buttons_n, input host_pwm,
                  output ready);
endinterface

interface hpb_out_if;
    logic       valid;
    logic       ready;
    logic       square_wave;
    logic       heater_on;
    logic [7:0] duty_setpoint;

    modport source (output valid, output square_wave, output heater_on,
                    output duty_setpoint, input ready);
    modport sink (input valid, input square_wave, input heater_on, input duty_setpoint,
                  output ready);
endinterface

[src/hpb_in_stage.sv]
// input register for one tick request
module hpb_in_stage
    import hpb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  hpb_item_t in_item,
    output logic      in_ready,
    input  logic      advance,
    output logic      item_valid,
    output hpb_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    hpb_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/hpb_core.sv]
// tick state: phase, duty counter, setpoint, button history, heater level
module hpb_core
    import hpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  hpb_item_t   item,
    input  hpb_cfg_t    cfg,
    output hpb_result_t result
);

    logic       phase_reg,    phase_next;
    logic [7:0] count_reg,    count_next;
    logic [7:0] setpoint_reg, setpoint_next;
    logic [3:0] last_btn_reg, last_btn_next;
    logic       heater_reg,   heater_next;

    logic [7:0] count_inc;
    logic       wrap;
    logic       heat_wrap;
    logic       press;
    logic [7:0] sp_plus;
    logic [7:0] sp_minus;
    logic [3:0] btn_ext;

    always_comb
    begin
        btn_ext   = {2'b00, item.buttons_n};
        count_inc = count_reg + 8'd1;
        wrap      = (count_inc == cfg.pwm_period);
        heat_wrap = wrap ? 1'b1 : heater_reg;
        press     = (btn_ext != last_btn_reg) && (last_btn_reg == BUTTONS_RELEASED);
        // plus applies first, minus is tested against the raised value
        sp_plus   = (press && !item.buttons_n[0] && (setpoint_reg < cfg.duty_max))
                    ? setpoint_reg + 8'd1 : setpoint_reg;
        sp_minus  = (press && !item.buttons_n[1] && (sp_plus > cfg.duty_min))
                    ? sp_plus - 8'd1 : sp_plus;

        phase_next    = !phase_reg;
        count_next    = count_reg;
        setpoint_next = setpoint_reg;
        last_btn_next = last_btn_reg;
        heater_next   = heater_reg;

        if (!phase_reg)
        begin
            if (item.manual_mode)
            begin
                count_next    = wrap ? 8'd0 : count_inc;
                heater_next   = ((wrap ? 8'd0 : count_inc) == setpoint_reg) ? 1'b0 : heat_wrap;
                setpoint_next = sp_minus;
                last_btn_next = btn_ext;
            end
            else
            begin
                heater_next = item.host_pwm;
            end
        end

        result.square_wave   = phase_next;
        result.heater_on     = heater_next;
        result.duty_setpoint = setpoint_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 1'b0;
            count_reg    <= 8'd0;
            setpoint_reg <= SETPOINT_RESET;
            last_btn_reg <= LAST_BUTTONS_RESET;
            heater_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            setpoint_reg <= setpoint_next;
            last_btn_reg <= last_btn_next;
            heater_reg   <= heater_next;
        end
    end

    a_phase_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> phase_reg != $past(phase_reg))
        else $error("phase did not toggle on a processed tick");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(setpoint_reg) && $stable(count_reg) && $stable(heater_reg))
        else $error("tick state moved without a processed tick");

    a_setpoint_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (setpoint_reg == $past(setpoint_reg)
                  || setpoint_reg == $past(setpoint_reg) + 8'd1
                  || setpoint_reg == $past(setpoint_reg) - 8'd1))
        else $error("setpoint moved by more than one step");

    a_falling_phase_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg |=> $stable(count_reg) && $stable(last_btn_reg))
        else $error("counter or buttons changed on a falling phase tick");

endmodule

[src/hpb_out_stage.sv]
// result register toward the output channel
module hpb_out_stage
    import hpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  hpb_result_t result,
    input  logic        out_ready,
    output logic        out_valid,
    output hpb_result_t out_result,
    output logic        can_load
);

    logic        valid_reg;
    logic        valid_next;
    hpb_result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

[src/heater_pwm_with_button_setpoint_top.sv]
// heater pwm top level: config registers and the two-register tick pipeline
//
// A tick request is accepted every clock cycle unless both registers hold an untaken tick:
// the tick is held in an input register, the phase, duty counter, setpoint and button state
// are updated from that register, and the result is held in an output register.
// Only the output register's ready feeds back, so the block sustains one tick per cycle as
// long as results are taken. Config writes (0 pwm_period, 1 duty_max, 2 duty_min; index 3 is
// ignored) take effect on the next cycle and are meant for when no tick is in flight.
module heater_pwm_with_button_setpoint_top
    import hpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    hpb_in_if.sink                in_ch,
    hpb_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    hpb_cfg_t    cfg_reg;
    hpb_cfg_t    cfg_next;
    hpb_item_t   in_item;
    hpb_item_t   item;
    logic        item_valid;
    logic        can_load;
    logic        fire;
    hpb_result_t result;
    hpb_result_t out_result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (hpb_reg_idx_t'(cfg_index))
                REG_PWM_PERIOD: cfg_next.pwm_period = cfg_data;
                REG_DUTY_MAX:   cfg_next.duty_max   = cfg_data;
                REG_DUTY_MIN:   cfg_next.duty_min   = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwm_period <= PWM_PERIOD_RESET;
            cfg_reg.duty_max   <= DUTY_MAX_RESET;
            cfg_reg.duty_min   <= DUTY_MIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_item.manual_mode = in_ch.manual_mode;
    assign in_item.buttons_n   = in_ch.buttons_n;
    assign in_item.host_pwm    = in_ch.host_pwm;

    assign fire = item_valid && can_load;

    hpb_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_item    (in_item),
        .in_ready   (in_ch.ready),
        .advance    (can_load),
        .item_valid (item_valid),
        .item       (item)
    );

    hpb_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    hpb_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result     (result),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_result (out_result),
        .can_load   (can_load)
    );

    assign out_ch.square_wave   = out_result.square_wave;
    assign out_ch.heater_on     = out_result.heater_on;
    assign out_ch.duty_setpoint = out_result.duty_setpoint;

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> item_valid && out_ch.valid && !out_ch.ready)
        else $error("input stalled while the pipeline had room");

    a_fire_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_ch.valid)
        else $error("processed tick did not reach the output register");

    a_cfg_ignored_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(cfg_reg))
        else $error("config changed without a write");

endmodule
